// ===== src/lrucache_pkg.sv =====
// Shared constants and types of the LRU cache tag-store model.
`default_nettype none

package lrucache_pkg;

  localparam int unsigned ADDR_W  = 64;
  localparam int unsigned TOT_W   = 32;
  localparam int unsigned HITS_W  = 2;
  localparam int unsigned SETB_W  = 4;
  localparam int unsigned BLKB_W  = 6;
  localparam int unsigned WAYSU_W = 4;
  localparam int unsigned SPLIT_W = 7;
  localparam int unsigned APB_DW  = 32;
  localparam int unsigned APB_AW  = 4;
  localparam int unsigned REG_IDX_W = 2;

  localparam logic [SETB_W-1:0]  SETB_RST  = 4'd4;
  localparam logic [BLKB_W-1:0]  BLKB_RST  = 6'd4;
  localparam logic [WAYSU_W-1:0] WAYSU_RST = 4'd1;

  localparam logic [REG_IDX_W-1:0] REG_SET_BITS   = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_BLOCK_BITS = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_WAYS_USED  = 2'd2;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_STORE  = 2'd1,
    OP_MODIFY = 2'd2,
    OP_IFETCH = 2'd3
  } op_e;

endpackage

`default_nettype wire

// ===== src/lrucache_if.sv =====
// Request and response channel interfaces of the LRU cache tag-store model.
`default_nettype none

interface lrucache_req_if;
  import lrucache_pkg::*;

  logic                valid;
  logic                ready;
  op_e                 op;
  logic [ADDR_W-1:0]   address;

  modport source (output valid, output op, output address, input ready);
  modport sink (input valid, input op, input address, output ready);
endinterface

interface lrucache_rsp_if;
  import lrucache_pkg::*;

  logic               valid;
  logic               ready;
  logic [HITS_W-1:0]  hits_now;
  logic               missed;
  logic               evicted;
  logic [TOT_W-1:0]   total_hits;
  logic [TOT_W-1:0]   total_misses;
  logic [TOT_W-1:0]   total_evictions;

  modport source (output valid, output hits_now, output missed, output evicted,
                  output total_hits, output total_misses, output total_evictions,
                  input ready);
  modport sink (input valid, input hits_now, input missed, input evicted,
                input total_hits, input total_misses, input total_evictions,
                output ready);
endinterface

`default_nettype wire

// ===== src/lrucache_set_store.sv =====
// Set memory holding tags, ages and valid bits of all ways, one row per set.
`default_nettype none

module lrucache_set_store #(
  parameter int unsigned MAX_SET_BITS = 8,
  parameter int unsigned WAYS         = 8
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic rd_en_i,
  input  logic wr_en_i,
  input  logic [(MAX_SET_BITS > 0 ? MAX_SET_BITS : 1)-1:0] set_i,
  input  logic [WAYS-1:0] wr_vld_i,
  input  logic [WAYS-1:0][lrucache_pkg::ADDR_W-1:0] wr_tag_i,
  input  logic [WAYS-1:0][(WAYS > 1 ? $clog2(WAYS) : 1)-1:0] wr_rec_i,
  output logic [WAYS-1:0] rd_vld_o,
  output logic [WAYS-1:0][lrucache_pkg::ADDR_W-1:0] rd_tag_o,
  output logic [WAYS-1:0][(WAYS > 1 ? $clog2(WAYS) : 1)-1:0] rd_rec_o
);
  import lrucache_pkg::*;

  localparam int unsigned NUM_SETS = 1 << MAX_SET_BITS;
  localparam int unsigned REC_W    = WAYS > 1 ? $clog2(WAYS) : 1;

  logic [WAYS-1:0]                mem_vld [NUM_SETS];
  logic [WAYS-1:0][ADDR_W-1:0]    mem_tag [NUM_SETS];
  logic [WAYS-1:0][REC_W-1:0]     mem_rec [NUM_SETS];
  logic [NUM_SETS-1:0]            row_ok_q;
  logic [WAYS-1:0]                rd_vld_q;
  logic [WAYS-1:0][ADDR_W-1:0]    rd_tag_q;
  logic [WAYS-1:0][REC_W-1:0]     rd_rec_q;

  // A row that was never written since reset reads as all ways invalid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_ok_q <= '0;
    end else if (wr_en_i) begin
      row_ok_q[set_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_vld[set_i] <= wr_vld_i;
      mem_tag[set_i] <= wr_tag_i;
      mem_rec[set_i] <= wr_rec_i;
    end
    if (rd_en_i) begin
      rd_vld_q <= row_ok_q[set_i] ? mem_vld[set_i] : '0;
      rd_tag_q <= mem_tag[set_i];
      rd_rec_q <= mem_rec[set_i];
    end
  end

  assign rd_vld_o = rd_vld_q;
  assign rd_tag_o = rd_tag_q;
  assign rd_rec_o = rd_rec_q;

endmodule

`default_nettype wire

// ===== src/lru_set_assoc_cache_sim.sv =====
// Top level of the set-associative LRU cache tag-store model.
//
// Accesses arrive as words on req_i (operation code and 64-bit address); each
// access yields exactly one response word on rsp_o with this access's hit,
// miss and eviction flags and the running 32-bit totals. Both channels use a
// valid/ready handshake; pready is always high. Over APB, the user must write
// set index, block offset widths and way count only when idle; not enforced.
//
// An access passes from acceptance through the decode state, which splits the
// address, the read state, which reads the set row, the scan state, where the
// shared tag comparator and age scan take one way per cycle, and the done
// state, which writes the row back and fills the response register. An
// instruction fetch goes straight to the done state and leaves the row as it
// is. req_i.ready is high only while no access is in progress.
//
// The response sits in an output register, so a new access is accepted while
// the last response still waits; a finished access holds before write-back
// until the response register is free. Reset clears the per-set valid flags
// at once (no clearing pass), the totals, and restores the default settings.
`default_nettype none

module lru_set_assoc_cache_sim #(
  parameter int unsigned MAX_SET_BITS = 8,
  parameter int unsigned WAYS         = 8
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  lrucache_req_if.sink                       req_i,
  lrucache_rsp_if.source                     rsp_o,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [lrucache_pkg::APB_AW-1:0]    paddr,
  input  logic [lrucache_pkg::APB_DW-1:0]    pwdata,
  output logic [lrucache_pkg::APB_DW-1:0]    prdata,
  output logic                               pready
);
  import lrucache_pkg::*;

  localparam int unsigned SET_W = MAX_SET_BITS > 0 ? MAX_SET_BITS : 1;
  localparam int unsigned WAY_W = WAYS > 1 ? $clog2(WAYS) : 1;
  localparam int unsigned REC_W = WAY_W;
  localparam int unsigned CNT_W = $clog2(WAYS + 1);
  localparam logic [REC_W-1:0] REC_MAX = REC_W'(WAYS - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_READ,
    ST_SCAN,
    ST_DONE
  } state_e;

  state_e                    state_q;
  logic [SETB_W-1:0]         set_bits_q;
  logic [BLKB_W-1:0]         block_bits_q;
  logic [WAYSU_W-1:0]        ways_used_q;

  op_e                       op_q;
  logic [ADDR_W-1:0]         addr_q;
  logic [ADDR_W-1:0]         tag_q;
  logic [SET_W-1:0]          set_q;
  logic [CNT_W-1:0]          e_q;
  logic [CNT_W-1:0]          w_q;
  logic                      found_q;
  logic [WAY_W-1:0]          fway_q;
  logic                      inv_q;
  logic [WAY_W-1:0]          iway_q;
  logic [REC_W-1:0]          oldest_q;
  logic [WAY_W-1:0]          vway_q;

  logic                      rsp_vld_q;
  logic [HITS_W-1:0]         hits_q;
  logic                      missed_q;
  logic                      evicted_q;
  logic [TOT_W-1:0]          hit_total_q;
  logic [TOT_W-1:0]          miss_total_q;
  logic [TOT_W-1:0]          evict_total_q;

  logic [SETB_W-1:0]         s_eff;
  logic [SPLIT_W-1:0]        split;
  logic [ADDR_W-1:0]         tag_d;
  logic [ADDR_W-1:0]         set_mask;
  logic [ADDR_W-1:0]         set_full;
  logic [CNT_W-1:0]          e_d;

  logic [WAYS-1:0]                rd_vld;
  logic [WAYS-1:0][ADDR_W-1:0]    rd_tag;
  logic [WAYS-1:0][REC_W-1:0]     rd_rec;
  logic [WAYS-1:0]                new_vld;
  logic [WAYS-1:0][ADDR_W-1:0]    new_tag;
  logic [WAYS-1:0][REC_W-1:0]     new_rec;

  logic [WAY_W-1:0]          cur;
  logic                      cur_vld;
  logic                      cur_hit;
  logic                      last_way;
  logic [REC_W-1:0]          age;
  logic [WAY_W-1:0]          slot;
  logic                      is_fetch;
  logic                      hit_now;
  logic                      miss_now;
  logic                      evict_now;
  logic [HITS_W-1:0]         hits_d;
  logic                      fire_done;
  logic                      cfg_wr;

  // Configuration registers.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_bits_q   <= SETB_RST;
      block_bits_q <= BLKB_RST;
      ways_used_q  <= WAYSU_RST;
    end else if (cfg_wr) begin
      unique case (paddr[APB_AW-1:2])
        REG_SET_BITS:   set_bits_q   <= pwdata[SETB_W-1:0];
        REG_BLOCK_BITS: block_bits_q <= pwdata[BLKB_W-1:0];
        REG_WAYS_USED:  ways_used_q  <= pwdata[WAYSU_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[APB_AW-1:2])
      REG_SET_BITS:   prdata = APB_DW'(set_bits_q);
      REG_BLOCK_BITS: prdata = APB_DW'(block_bits_q);
      REG_WAYS_USED:  prdata = APB_DW'(ways_used_q);
      default:        prdata = '0;
    endcase
  end

  // Address split.
  assign s_eff    = (32'(set_bits_q) > MAX_SET_BITS) ? SETB_W'(MAX_SET_BITS) : set_bits_q;
  assign split    = SPLIT_W'(s_eff) + SPLIT_W'(block_bits_q);
  assign tag_d    = (split >= SPLIT_W'(64)) ? '0 : (addr_q >> split);
  assign set_mask = ~({ADDR_W{1'b1}} << s_eff);
  assign set_full = (addr_q >> block_bits_q) & set_mask;
  assign e_d      = (ways_used_q == '0) ? CNT_W'(1) :
                    (32'(ways_used_q) > WAYS) ? CNT_W'(WAYS) : CNT_W'(ways_used_q);

  lrucache_set_store #(
    .MAX_SET_BITS (MAX_SET_BITS),
    .WAYS         (WAYS)
  ) u_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_en_i  (state_q == ST_READ),
    .wr_en_i  (fire_done && !is_fetch),
    .set_i    (set_q),
    .wr_vld_i (new_vld),
    .wr_tag_i (new_tag),
    .wr_rec_i (new_rec),
    .rd_vld_o (rd_vld),
    .rd_tag_o (rd_tag),
    .rd_rec_o (rd_rec)
  );

  // Shared tag comparator and age scan, one way per cycle.
  assign cur      = w_q[WAY_W-1:0];
  assign cur_vld  = rd_vld[cur];
  assign cur_hit  = cur_vld && (rd_tag[cur] == tag_q);
  assign last_way = (w_q == e_q - CNT_W'(1));

  // Row update.
  assign age   = rd_rec[fway_q];
  assign slot  = inv_q ? iway_q : vway_q;

  always_comb begin
    new_vld = rd_vld;
    new_tag = rd_tag;
    new_rec = rd_rec;
    for (int w = 0; w < WAYS; w++) begin
      if (CNT_W'(w) < e_q && rd_vld[w]) begin
        if (found_q) begin
          if (WAY_W'(w) != fway_q && rd_rec[w] < age) begin
            new_rec[w] = rd_rec[w] + REC_W'(1);
          end
        end else begin
          if (WAY_W'(w) != slot && rd_rec[w] < REC_MAX) begin
            new_rec[w] = rd_rec[w] + REC_W'(1);
          end
        end
      end
    end
    if (found_q) begin
      new_rec[fway_q] = '0;
    end else begin
      new_vld[slot] = 1'b1;
      new_tag[slot] = tag_q;
      new_rec[slot] = '0;
    end
  end

  assign is_fetch  = (op_q == OP_IFETCH);
  assign hit_now   = found_q && !is_fetch;
  assign miss_now  = !found_q && !is_fetch;
  assign evict_now = miss_now && !inv_q;
  assign hits_d    = HITS_W'(hit_now) + HITS_W'(op_q == OP_MODIFY);
  assign fire_done = (state_q == ST_DONE) && (!rsp_vld_q || rsp_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      op_q          <= OP_LOAD;
      addr_q        <= '0;
      tag_q         <= '0;
      set_q         <= '0;
      e_q           <= '0;
      w_q           <= '0;
      found_q       <= 1'b0;
      fway_q        <= '0;
      inv_q         <= 1'b0;
      iway_q        <= '0;
      oldest_q      <= '0;
      vway_q        <= '0;
      rsp_vld_q     <= 1'b0;
      hits_q        <= '0;
      missed_q      <= 1'b0;
      evicted_q     <= 1'b0;
      hit_total_q   <= '0;
      miss_total_q  <= '0;
      evict_total_q <= '0;
    end else begin
      if (fire_done) begin
        rsp_vld_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_vld_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (req_i.valid) begin
            op_q    <= req_i.op;
            addr_q  <= req_i.address;
            state_q <= (req_i.op == OP_IFETCH) ? ST_DONE : ST_DECODE;
          end
        end
        ST_DECODE: begin
          tag_q   <= tag_d;
          set_q   <= set_full[SET_W-1:0];
          e_q     <= e_d;
          state_q <= ST_READ;
        end
        ST_READ: begin
          w_q      <= '0;
          found_q  <= 1'b0;
          fway_q   <= '0;
          inv_q    <= 1'b0;
          iway_q   <= '0;
          oldest_q <= '0;
          vway_q   <= '0;
          state_q  <= ST_SCAN;
        end
        ST_SCAN: begin
          if (!found_q && cur_hit) begin
            found_q <= 1'b1;
            fway_q  <= cur;
          end
          if (!inv_q && !cur_vld) begin
            inv_q  <= 1'b1;
            iway_q <= cur;
          end
          if (rd_rec[cur] >= oldest_q) begin
            oldest_q <= rd_rec[cur];
            vway_q   <= cur;
          end
          if (last_way) begin
            state_q <= ST_DONE;
          end else begin
            w_q <= w_q + CNT_W'(1);
          end
        end
        ST_DONE: begin
          if (fire_done) begin
            hits_q        <= hits_d;
            missed_q      <= miss_now;
            evicted_q     <= evict_now;
            hit_total_q   <= hit_total_q + TOT_W'(hits_d);
            miss_total_q  <= miss_total_q + TOT_W'(miss_now);
            evict_total_q <= evict_total_q + TOT_W'(evict_now);
            state_q       <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign req_i.ready           = (state_q == ST_IDLE);
  assign rsp_o.valid           = rsp_vld_q;
  assign rsp_o.hits_now        = hits_q;
  assign rsp_o.missed          = missed_q;
  assign rsp_o.evicted         = evicted_q;
  assign rsp_o.total_hits      = hit_total_q;
  assign rsp_o.total_misses    = miss_total_q;
  assign rsp_o.total_evictions = evict_total_q;

endmodule

`default_nettype wire

// ===== src/lrucache_chk.sv =====
// Port-level checker for the LRU cache tag-store model and its bind.
`default_nettype none

module lrucache_chk (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              req_valid_i,
  input logic                              req_ready_i,
  input logic                              rsp_valid_i,
  input logic                              rsp_ready_i,
  input logic [lrucache_pkg::HITS_W-1:0]   hits_now_i,
  input logic                              missed_i,
  input logic                              evicted_i,
  input logic [lrucache_pkg::TOT_W-1:0]    total_hits_i,
  input logic [lrucache_pkg::TOT_W-1:0]    total_misses_i,
  input logic [lrucache_pkg::TOT_W-1:0]    total_evictions_i
);
  import lrucache_pkg::*;

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(hits_now_i) &&
      $stable(missed_i) && $stable(evicted_i) && $stable(total_hits_i))
    else $error("Response word changed while stalled.");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("Request accepted while an access was in progress.");

  a_hit_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_i) |-> total_hits_i == $past(total_hits_i) + TOT_W'(hits_now_i))
    else $error("Hit total does not match the hits of this word.");

  a_miss_evict_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_i) |->
      total_misses_i == $past(total_misses_i) + TOT_W'(missed_i) &&
      total_evictions_i == $past(total_evictions_i) + TOT_W'(evicted_i))
    else $error("Miss or eviction total does not match this word.");

endmodule

bind lru_set_assoc_cache_sim lrucache_chk u_chk (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .req_valid_i       (req_i.valid),
  .req_ready_i       (req_i.ready),
  .rsp_valid_i       (rsp_o.valid),
  .rsp_ready_i       (rsp_o.ready),
  .hits_now_i        (rsp_o.hits_now),
  .missed_i          (rsp_o.missed),
  .evicted_i         (rsp_o.evicted),
  .total_hits_i      (rsp_o.total_hits),
  .total_misses_i    (rsp_o.total_misses),
  .total_evictions_i (rsp_o.total_evictions)
);

`default_nettype wire
